[hw/rtl/lru_recent_key_list_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the recent key list
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRU_RECENT_KEY_LIST_DEFINES_SVH
`define LRU_RECENT_KEY_LIST_DEFINES_SVH

// Same-cycle implication
`define LRUKL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LRUKL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/lrukl_pkg.sv]
// ----------------------------------------------------------------------------
// lrukl_pkg
// Sizes and codes shared by the recent key list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrukl_pkg;

    localparam int DEPTH      = 10;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = 4;

    localparam int S_TDATA_W  = ((ENTRY_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((ENTRY_BITS + POS_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // operation code carried on the input tuser
    localparam logic OP_DUMP = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/lrukl_ram.sv]
// ----------------------------------------------------------------------------
// lrukl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrukl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/lru_recent_key_list.sv]
// Record word: accepted in S_IDLE, then one search step per cycle through the entry RAM;
//   a hit at rank i ends the search there, a miss runs to the tail and then inserts (search + insert).
// Dump word: S_DUMP registers the first result after accept, then one result per cycle unless stalled.
// Results sit in an output register, so a new word is taken while the last one waits.
// Synchronous active-low reset empties the list; the entry RAM is never cleared.
// ----------------------------------------------------------------------------
// lru_recent_key_list
// Move-to-front list of key/value entries held in a RAM, ordered by a row of
// slot pointers, with a dump stream from newest to oldest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_recent_key_list_defines.svh"

module lru_recent_key_list (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side
    input  wire logic                             i_s_tvalid,
    output      logic                             o_s_tready,
    input  wire logic [lrukl_pkg::S_TDATA_W-1:0]  i_s_tdata,  // key, value
    input  wire logic                             i_s_tuser,  // operation
    // master side
    output      logic                             o_m_tvalid,
    input  wire logic                             i_m_tready,
    output      logic [lrukl_pkg::M_TDATA_W-1:0]  o_m_tdata,  // entry_key, entry_value, position
    output      logic                             o_m_tuser,  // entry_valid
    output      logic                             o_m_tlast   // last
);

    localparam int KB = lrukl_pkg::KEY_BITS;
    localparam int VB = lrukl_pkg::VALUE_BITS;
    localparam int SW = lrukl_pkg::SLOT_W;
    localparam int CW = lrukl_pkg::CNT_W;
    localparam int PW = lrukl_pkg::POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_DUMP
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [SW-1:0]   r_idx,   n_idx;
    logic [SW-1:0]   r_slot;
    logic [KB-1:0]   r_key,   n_key;
    logic [VB-1:0]   r_value, n_value;
    logic [SW-1:0]   r_order [lrukl_pkg::DEPTH];
    logic [SW-1:0]   n_order [lrukl_pkg::DEPTH];

    logic            r_out_valid, n_out_valid;
    logic            r_out_flag,  n_out_flag;
    logic            r_out_last,  n_out_last;
    logic [KB-1:0]   r_out_key,   n_out_key;
    logic [VB-1:0]   r_out_value, n_out_value;
    logic [PW-1:0]   r_out_pos,   n_out_pos;

    logic                              ram_we;
    logic [SW-1:0]                     ram_waddr;
    logic [SW-1:0]                     ram_raddr;
    logic [lrukl_pkg::ENTRY_BITS-1:0]  ram_rdata;
    logic [KB-1:0]                     ram_rkey;
    logic [VB-1:0]                     ram_rvalue;
    logic [SW-1:0]                     shift_upto;
    logic                              out_free;
    logic                              at_tail;

    assign ram_rkey   = ram_rdata[KB-1:0];
    assign ram_rvalue = ram_rdata[KB+VB-1:KB];
    assign ram_raddr  = r_order[n_idx];
    assign out_free   = !r_out_valid || i_m_tready;
    assign at_tail    = (CW'(r_idx) + CW'(1)) == r_count;

    lrukl_ram #(
        .WIDTH (lrukl_pkg::ENTRY_BITS),
        .DEPTH (lrukl_pkg::DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_value, r_key}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_key       = r_key;
        n_value     = r_value;
        n_order     = r_order;
        n_out_valid = r_out_valid;
        n_out_flag  = r_out_flag;
        n_out_last  = r_out_last;
        n_out_key   = r_out_key;
        n_out_value = r_out_value;
        n_out_pos   = r_out_pos;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        shift_upto  = '0;

        // drop the word once taken
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_key   = i_s_tdata[KB-1:0];
                    n_value = i_s_tdata[KB+VB-1:KB];
                    n_idx   = '0;
                    if (i_s_tuser == lrukl_pkg::OP_DUMP) begin
                        n_state = S_DUMP;
                    end else if (r_count == '0) begin
                        n_state = S_INS;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (ram_rkey == r_key) begin
                    n_state = S_IDLE;
                    // hit further back: new value, pointer to the front
                    if (r_idx != '0) begin
                        ram_we     = 1'b1;
                        ram_waddr  = r_slot;
                        shift_upto = r_idx;
                    end
                end else if (at_tail) begin
                    n_state = S_INS;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            S_INS: begin
                ram_we  = 1'b1;
                n_state = S_IDLE;
                if (r_count < lrukl_pkg::CNT_FULL) begin
                    ram_waddr  = r_count[SW-1:0];
                    shift_upto = r_count[SW-1:0];
                    n_count    = r_count + CW'(1);
                end else begin
                    // full: reuse the oldest slot
                    ram_waddr  = r_order[lrukl_pkg::DEPTH-1];
                    shift_upto = SW'(lrukl_pkg::DEPTH - 1);
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_count == '0) begin
                        n_out_flag  = 1'b0;
                        n_out_last  = 1'b1;
                        n_out_key   = '0;
                        n_out_value = '0;
                        n_out_pos   = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_out_flag  = 1'b1;
                        n_out_last  = at_tail;
                        n_out_key   = ram_rkey;
                        n_out_value = ram_rvalue;
                        n_out_pos   = PW'(r_idx);
                        if (at_tail) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = r_idx + SW'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // move the written slot to the front, push the ones before it back
        if (ram_we) begin
            n_order[0] = ram_waddr;
            for (int j = 1; j < lrukl_pkg::DEPTH; j++) begin
                if (SW'(j) <= shift_upto) begin
                    n_order[j] = r_order[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_slot      <= ram_raddr;
        r_key       <= n_key;
        r_value     <= n_value;
        r_out_flag  <= n_out_flag;
        r_out_last  <= n_out_last;
        r_out_key   <= n_out_key;
        r_out_value <= n_out_value;
        r_out_pos   <= n_out_pos;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < lrukl_pkg::DEPTH; j++) begin
                r_order[j] <= SW'(j);
            end
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_order     <= n_order;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = lrukl_pkg::M_TDATA_W'({r_out_pos, r_out_value, r_out_key});
    assign o_m_tuser  = r_out_flag;
    assign o_m_tlast  = r_out_last;

    `LRUKL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= lrukl_pkg::CNT_FULL,
        "entry count beyond depth")
    `LRUKL_ASSERT_NOW(a_index_in_list,
        (r_state == S_SCAN) || ((r_state == S_DUMP) && (r_count != '0)),
        CW'(r_idx) < r_count, "search index past the occupied entries")
    `LRUKL_ASSERT_NEXT(a_insert_grows,
        r_state == S_INS,
        (r_count == $past(r_count) + CW'(1)) || (r_count == lrukl_pkg::CNT_FULL),
        "insert did not grow a list that had room")
    `LRUKL_ASSERT_NEXT(a_full_stays_full,
        (r_state == S_INS) && (r_count == lrukl_pkg::CNT_FULL),
        r_count == lrukl_pkg::CNT_FULL, "full list lost an entry on insert")
    `LRUKL_ASSERT_NEXT(a_dump_ends,
        (r_state == S_DUMP) && out_free && ((r_count == '0) || at_tail),
        r_state == S_IDLE, "dump carried on past its final word")

endmodule

`default_nettype wire

[tb/lru_recent_key_list_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_recent_key_list_test
// Drives record and dump words into the recent key list and checks every
// dump result against a move-to-front list kept alongside the block. Directed
// cases come first, then random traffic under four idling patterns.
// ----------------------------------------------------------------------------

module lru_recent_key_list_test;

    import lrukl_pkg::*;

    localparam logic OP_RECORD    = 1'b0;
    localparam int   CLK_HALF     = 5;
    localparam int   RESET_CYCLES = 9;
    localparam int   CYCLE_LIMIT  = 300000;
    localparam int   DRAIN_CYCLES = 40;
    localparam int   REPORT_MAX   = 10;
    localparam int   POOL_SIZE    = 14;
    localparam int   PHASE_WORDS  = 31;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [POS_W-1:0]      pos;
        logic                  last;
    } t_dump_entry;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;   // key, value
    logic                 i_s_tuser;   // operation
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;   // entry_key, entry_value, position
    logic                 o_m_tuser;   // entry_valid
    logic                 o_m_tlast;   // last

    // recency list as the block should hold it
    logic [KEY_BITS-1:0]   lru_keys   [DEPTH];
    logic [VALUE_BITS-1:0] lru_values [DEPTH];
    int                    lru_count;

    t_dump_entry pending_entries[$];
    int          mismatch_count;
    int          cycle_count;
    int          send_idle_pct;
    int          stall_pct;

    lru_recent_key_list dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic void apply_record(input logic [KEY_BITS-1:0] k,
                                         input logic [VALUE_BITS-1:0] v);
        int hit;
        int i;
        hit = -1;
        for (i = 0; i < lru_count; i++) begin
            if (hit < 0 && lru_keys[i] == k) hit = i;
        end
        // front hit: leave the old value in place
        if (hit == 0) return;
        if (hit < 0) begin
            if (lru_count < DEPTH) lru_count++;
            hit = lru_count - 1;
        end
        for (i = hit; i > 0; i--) begin
            lru_keys[i]   = lru_keys[i-1];
            lru_values[i] = lru_values[i-1];
        end
        lru_keys[0]   = k;
        lru_values[0] = v;
    endfunction

    function automatic void queue_dump_entries();
        int          i;
        t_dump_entry e;
        if (lru_count == 0) begin
            e = '{valid: 1'b0, key: '0, value: '0, pos: '0, last: 1'b1};
            pending_entries = {pending_entries, e};
            return;
        end
        for (i = 0; i < lru_count; i++) begin
            e = '{valid: 1'b1, key: lru_keys[i], value: lru_values[i],
                  pos: POS_W'(i), last: (i == lru_count - 1)};
            pending_entries = {pending_entries, e};
        end
    endfunction

    // Entered and left at a falling edge.
    task automatic send_word(input logic op, input logic [KEY_BITS-1:0] k,
                             input logic [VALUE_BITS-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'({v, k});
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        if (op == OP_DUMP) queue_dump_entries();
        else apply_record(k, v);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_dump_entry want;
        t_dump_entry got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{valid: o_m_tuser, key: o_m_tdata[KEY_BITS-1:0],
                    value: o_m_tdata[ENTRY_BITS-1:KEY_BITS],
                    pos: o_m_tdata[ENTRY_BITS+POS_W-1:ENTRY_BITS], last: o_m_tlast};
            if (pending_entries.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: valid=%0b key=%h value=%h pos=%0d last=%0b",
                             got.valid, got.key, got.value, got.pos, got.last);
            end else begin
                want = pending_entries.pop_front();
                if (got.valid !== want.valid || got.key !== want.key ||
                    got.value !== want.value || got.pos !== want.pos ||
                    got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("mismatch: expected valid=%0b key=%h value=%h pos=%0d last=%0b",
                                 want.valid, want.key, want.value, want.pos, want.last);
                        $display("          actual   valid=%0b key=%h value=%h pos=%0d last=%0b",
                                 got.valid, got.key, got.value, got.pos, got.last);
                    end
                end
            end
        end
    end

    task automatic test_empty_dump();
        send_word(OP_DUMP, '1, '1);
        send_word(OP_DUMP, '0, '0);
    endtask

    task automatic test_field_extremes();
        send_word(OP_RECORD, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(OP_RECORD, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(OP_RECORD, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_word(OP_DUMP, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    endtask

    // a repeat of the newest key keeps its old value
    task automatic test_front_hit();
        send_word(OP_RECORD, 32'hA5A5_A5A5, 32'h0000_0001);
        send_word(OP_DUMP, '0, '0);
    endtask

    task automatic test_move_to_front();
        send_word(OP_RECORD, 32'h0000_0000, 32'h1234_5678);
        send_word(OP_RECORD, 32'hA5A5_A5A5, 32'hCAFE_0001);
        send_word(OP_DUMP, '0, '0);
    endtask

    // overfill, then hit the oldest entry and bring back an evicted key
    task automatic test_eviction();
        int i;
        for (i = 0; i < DEPTH; i++)
            send_word(OP_RECORD, 32'h1000_0000 + i, 32'h2000_0000 + i);
        send_word(OP_DUMP, '0, '0);
        send_word(OP_RECORD, lru_keys[DEPTH-1], 32'h3000_0000);
        send_word(OP_RECORD, 32'hA5A5_A5A5, 32'h3000_0001);
        send_word(OP_DUMP, '0, '0);
    endtask

    task automatic test_random_traffic(input int words, input int idle_pct,
                                       input int hold_pct);
        logic [KEY_BITS-1:0] key_pool[POOL_SIZE];
        int                  i;
        int                  pick;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        for (i = 0; i < words; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 22)
                send_word(OP_DUMP, $urandom, $urandom);
            else if (pick < 82)
                send_word(OP_RECORD, key_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom);
            else
                send_word(OP_RECORD, $urandom, $urandom);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = OP_RECORD;
        i_m_tready     = 1'b1;
        lru_count      = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_dump();
        test_field_extremes();
        test_front_hit();
        test_move_to_front();
        test_eviction();
        test_random_traffic(PHASE_WORDS, 0, 0);
        test_random_traffic(PHASE_WORDS, 51, 0);
        test_random_traffic(PHASE_WORDS, 0, 51);
        test_random_traffic(PHASE_WORDS, 34, 34);

        i_s_tvalid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_entries.size() != 0) begin
            mismatch_count++;
            $display("%0d dump results never arrived", pending_entries.size());
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
